// ===== sv/wgrm_pkg.sv =====
// wgrm_pkg: shared types, constants and the hat decode table for the
// wheel to gamepad report mapper. No dependencies.
package wgrm_pkg;

  localparam int RemW  = 30;
  localparam int QuoW  = 15;
  localparam int CfgW  = 15;
  localparam int IdxW  = 2;

  typedef enum logic [IdxW-1:0] {
    CFG_STEER_RANGE     = 2'd0,
    CFG_DEAD_ZONE       = 2'd1,
    CFG_GAS_THRESHOLD   = 2'd2,
    CFG_BRAKE_THRESHOLD = 2'd3
  } cfg_idx_t;

  localparam logic [14:0] STEER_RANGE_RST     = 15'd5000;
  localparam logic [14:0] DEAD_ZONE_RST       = 15'd2048;
  localparam logic [7:0]  GAS_THRESHOLD_RST   = 8'd127;
  localparam logic [7:0]  BRAKE_THRESHOLD_RST = 8'd55;

  localparam logic [7:0]      TRIG_FULL = 8'hFF;
  localparam logic [7:0]      PEDAL_TOP = 8'hFF;
  localparam logic [QuoW-1:0] STICK_MAX = 15'h7FFF;

  localparam logic [15:0] PAD_UP    = 16'h0001;
  localparam logic [15:0] PAD_DOWN  = 16'h0002;
  localparam logic [15:0] PAD_LEFT  = 16'h0004;
  localparam logic [15:0] PAD_RIGHT = 16'h0008;
  localparam logic [15:0] PAD_START = 16'h0010;
  localparam logic [15:0] PAD_GUIDE = 16'h0400;
  localparam logic [15:0] PAD_A     = 16'h1000;
  localparam logic [15:0] PAD_B     = 16'h2000;
  localparam logic [15:0] PAD_X     = 16'h4000;
  localparam logic [15:0] PAD_Y     = 16'h8000;

  typedef struct packed {
    logic [14:0] steer_range;
    logic [14:0] dead_zone;
    logic [7:0]  gas_threshold;
    logic [7:0]  brake_threshold;
  } cfg_t;

  typedef struct packed {
    logic [15:0]     pad;
    logic            lt;
    logic            rt;
    logic            neg;
    logic            sat;
    logic [RemW-1:0] rem;
    logic [QuoW-1:0] quo;
  } pipe_t;

  function automatic logic [15:0] hat_dpad(input logic [3:0] code);
    logic [15:0] r;
    unique case (code)
      4'd0:    r = PAD_UP;
      4'd1:    r = PAD_UP | PAD_RIGHT;
      4'd2:    r = PAD_RIGHT;
      4'd3:    r = PAD_DOWN | PAD_RIGHT;
      4'd4:    r = PAD_DOWN;
      4'd5:    r = PAD_DOWN | PAD_LEFT;
      4'd6:    r = PAD_LEFT;
      4'd7:    r = PAD_UP | PAD_LEFT;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/wgrm_if.sv =====
// wgrm channel interfaces: wheel report and gamepad report, valid/ready.
// Depends on nothing.
interface wgrm_wheel_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_buttons;
  logic [15:0] wheel_position;
  logic [7:0]  gas_level;
  logic [7:0]  brake_level;
  modport source(output valid, raw_buttons, wheel_position, gas_level, brake_level,
                 input ready);
  modport sink(input valid, raw_buttons, wheel_position, gas_level, brake_level,
               output ready);
endinterface

interface wgrm_pad_if;
  logic               valid;
  logic               ready;
  logic [15:0]        pad_buttons;
  logic [7:0]         left_trigger;
  logic [7:0]         right_trigger;
  logic signed [15:0] stick_x;
  modport source(output valid, pad_buttons, left_trigger, right_trigger, stick_x,
                 input ready);
  modport sink(input valid, pad_buttons, left_trigger, right_trigger, stick_x,
               output ready);
endinterface

// ===== sv/wgrm_pipe_reg.sv =====
// wgrm_pipe_reg: one valid/ready pipeline register of the mapper pipeline.
// Depends on wgrm_pkg.
module wgrm_pipe_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  wgrm_pkg::pipe_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output wgrm_pkg::pipe_t dn_data
);
  import wgrm_pkg::*;

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= up_data;
    end
  end
endmodule

// ===== sv/wgrm_decode.sv =====
// wgrm_decode: button remap, hat decode, pedal compare and wheel magnitude.
// Depends on wgrm_pkg.
module wgrm_decode (
  input  logic [15:0]     raw_buttons,
  input  logic [15:0]     wheel_position,
  input  logic [7:0]      gas_level,
  input  logic [7:0]      brake_level,
  input  wgrm_pkg::cfg_t  cfg,
  output wgrm_pkg::pipe_t dec
);
  import wgrm_pkg::*;

  logic [15:0] pad;
  logic [15:0] mag;

  always_comb begin
    pad = hat_dpad(raw_buttons[3:0]);
    if (raw_buttons[4])  pad = pad | PAD_A;
    if (raw_buttons[5])  pad = pad | PAD_B;
    if (raw_buttons[6])  pad = pad | PAD_X;
    if (raw_buttons[7])  pad = pad | PAD_Y;
    if (raw_buttons[10]) pad = pad | PAD_START;
    if (raw_buttons[11]) pad = pad | PAD_GUIDE;
    if (gas_level < (PEDAL_TOP - cfg.gas_threshold))     pad = pad | PAD_B;
    if (brake_level < (PEDAL_TOP - cfg.brake_threshold)) pad = pad | PAD_A;
  end

  // distance from center, 32768 at most
  assign mag = wheel_position[15] ? {1'b0, wheel_position[14:0]}
                                  : 16'(17'h10000 - 17'(wheel_position) - 17'h08000);

  always_comb begin
    dec     = '0;
    dec.pad = pad;
    dec.lt  = raw_buttons[9];
    dec.rt  = raw_buttons[8];
    dec.neg = !wheel_position[15];
    dec.rem = RemW'(mag);
  end
endmodule

// ===== sv/wgrm_scale.sv =====
// wgrm_scale: magnitude times 32767 and the saturation test against the range.
// Depends on wgrm_pkg.
module wgrm_scale (
  input  wgrm_pkg::pipe_t din,
  input  logic [14:0]     range_eff,
  output wgrm_pkg::pipe_t dout
);
  import wgrm_pkg::*;

  logic [15:0] mag;
  logic [30:0] prod;

  assign mag  = din.rem[15:0];
  assign prod = {mag, 15'd0} - 31'(mag);

  always_comb begin
    dout     = din;
    dout.rem = prod[RemW-1:0];
    dout.sat = prod[RemW-1:QuoW] >= range_eff;
    dout.quo = '0;
  end
endmodule

// ===== sv/wgrm_div_step.sv =====
// wgrm_div_step: a few restoring division steps, quotient bits HI down.
// Depends on wgrm_pkg.
module wgrm_div_step #(
  parameter int HI    = 14,
  parameter int STEPS = 3
) (
  input  wgrm_pkg::pipe_t din,
  input  logic [14:0]     range_eff,
  output wgrm_pkg::pipe_t dout
);
  import wgrm_pkg::*;

  always_comb begin
    logic [RemW-1:0] trial;
    dout = din;
    for (int k = 0; k < STEPS; k++) begin
      trial = RemW'(range_eff) << (HI - k);
      if (dout.rem >= trial) begin
        dout.rem          = dout.rem - trial;
        dout.quo[HI - k]  = 1'b1;
      end
    end
  end
endmodule

// ===== sv/wheel_to_gamepad_report_map.sv =====
// wheel_to_gamepad_report_map: top level, config registers, pipeline, output.
// Depends on wgrm_pkg, wgrm_if and the wgrm submodules.
//
// Maps one wheel report to one gamepad report. A new request is taken every
// cycle while the pad output is not stalled. The stick axis comes from a
// 15-bit restoring divider, which resolves 3 quotient bits per pipeline
// stage over 5 stages after a decode stage and a scale stage. The output
// register and per-stage valid bits let requests keep entering while a
// result waits. Configuration must be written with the pipeline empty.
module wheel_to_gamepad_report_map (
  input  logic                       clk,
  input  logic                       rst,
  wgrm_wheel_if.sink                 wheel,
  wgrm_pad_if.source                 pad,
  input  logic                       cfg_wr_en,
  input  logic [wgrm_pkg::IdxW-1:0]  cfg_index,
  input  logic [wgrm_pkg::CfgW-1:0]  cfg_data
);
  import wgrm_pkg::*;

  localparam int NDIV = 5;
  localparam int NREG = NDIV + 2;

  cfg_t        cfg;
  logic [14:0] range_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_range     <= STEER_RANGE_RST;
      cfg.dead_zone       <= DEAD_ZONE_RST;
      cfg.gas_threshold   <= GAS_THRESHOLD_RST;
      cfg.brake_threshold <= BRAKE_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEER_RANGE:     cfg.steer_range     <= cfg_data;
        CFG_DEAD_ZONE:       cfg.dead_zone       <= cfg_data;
        CFG_GAS_THRESHOLD:   cfg.gas_threshold   <= cfg_data[7:0];
        CFG_BRAKE_THRESHOLD: cfg.brake_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign range_eff = (cfg.steer_range == '0) ? 15'd1 : cfg.steer_range;

  pipe_t st_in  [NREG];
  pipe_t st_out [NREG];
  logic  st_vin [NREG];
  logic  st_rdy [NREG];
  logic  st_v   [NREG];
  logic  st_dr  [NREG];

  wgrm_decode u_decode (
    .raw_buttons    (wheel.raw_buttons),
    .wheel_position (wheel.wheel_position),
    .gas_level      (wheel.gas_level),
    .brake_level    (wheel.brake_level),
    .cfg            (cfg),
    .dec            (st_in[0])
  );

  wgrm_scale u_scale (
    .din       (st_out[0]),
    .range_eff (range_eff),
    .dout      (st_in[1])
  );

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    wgrm_div_step #(.HI(QuoW - 1 - 3 * g), .STEPS(3)) u_step (
      .din       (st_out[g + 1]),
      .range_eff (range_eff),
      .dout      (st_in[g + 2])
    );
  end

  assign st_vin[0]  = wheel.valid;
  assign wheel.ready = st_rdy[0];

  for (genvar s = 0; s < NREG; s++) begin : g_stage
    if (s > 0) begin : g_link
      assign st_vin[s]    = st_v[s - 1];
      assign st_dr[s - 1] = st_rdy[s];
    end
    wgrm_pipe_reg u_reg (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_vin[s]),
      .up_ready (st_rdy[s]),
      .up_data  (st_in[s]),
      .dn_valid (st_v[s]),
      .dn_ready (st_dr[s]),
      .dn_data  (st_out[s])
    );
  end

  pipe_t           last;
  logic            out_ready;
  logic [QuoW-1:0] q_sat;
  logic [QuoW-1:0] q_dz;
  logic [15:0]     stick_next;

  assign last            = st_out[NREG - 1];
  assign out_ready       = !pad.valid || pad.ready;
  assign st_dr[NREG - 1] = out_ready;

  assign q_sat      = last.sat ? STICK_MAX : last.quo;
  assign q_dz       = (q_sat < cfg.dead_zone) ? '0 : q_sat;
  assign stick_next = last.neg ? 16'(17'h10000 - 17'(q_dz)) : 16'(q_dz);

  always_ff @(posedge clk) begin
    if (rst) begin
      pad.valid <= 1'b0;
    end else if (out_ready) begin
      pad.valid <= st_v[NREG - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && st_v[NREG - 1]) begin
      pad.pad_buttons   <= last.pad;
      pad.left_trigger  <= last.lt ? TRIG_FULL : 8'd0;
      pad.right_trigger <= last.rt ? TRIG_FULL : 8'd0;
      pad.stick_x       <= stick_next;
    end
  end
endmodule

// ===== sv/wgrm_checker.sv =====
// wgrm_checker: port-level checks on the mapper, bound to the top level.
// Depends on wheel_to_gamepad_report_map and wgrm_if.
module wgrm_checker (
  input logic        clk,
  input logic        rst,
  input logic        pad_valid,
  input logic        pad_ready,
  input logic [15:0] pad_buttons,
  input logic [7:0]  left_trigger,
  input logic [7:0]  right_trigger,
  input logic [15:0] stick_x
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    pad_valid && !pad_ready |=> pad_valid)
    else $error("pad request dropped while stalled");

  a_hold_data : assert property (@(posedge clk) disable iff (rst)
    pad_valid && !pad_ready |=> $stable(stick_x) && $stable(pad_buttons))
    else $error("pad request changed while stalled");

  a_unused_bits : assert property (@(posedge clk) disable iff (rst)
    pad_valid |-> (pad_buttons & 16'h0BE0) == 16'h0000)
    else $error("unmapped pad button bit set");

  a_triggers : assert property (@(posedge clk) disable iff (rst)
    pad_valid |-> (left_trigger == 8'h00 || left_trigger == 8'hFF) &&
                  (right_trigger == 8'h00 || right_trigger == 8'hFF))
    else $error("trigger not empty or full");

  a_stick_range : assert property (@(posedge clk) disable iff (rst)
    pad_valid |-> stick_x != 16'h8000)
    else $error("stick beyond saturation");

endmodule

bind wheel_to_gamepad_report_map wgrm_checker u_wgrm_checker (
  .clk           (clk),
  .rst           (rst),
  .pad_valid     (pad.valid),
  .pad_ready     (pad.ready),
  .pad_buttons   (pad.pad_buttons),
  .left_trigger  (pad.left_trigger),
  .right_trigger (pad.right_trigger),
  .stick_x       (pad.stick_x)
);
